// ===== design/rhc_pkg.sv =====
// Shared types and constants for the RGB to HSV converter.
`default_nettype none

package rhc_pkg;

  localparam int HUE_FRAC_BITS_DEF = 6;
  localparam int CH_W  = 8;
  localparam int HUE_W = 15;

  // hue sector, chosen by the largest channel (red over green over blue on ties)
  localparam logic [1:0] SEC_RED = 2'd0;
  localparam logic [1:0] SEC_GRN = 2'd1;
  localparam logic [1:0] SEC_BLU = 2'd2;

  localparam int OFS_GRN = 120;
  localparam int OFS_BLU = 240;
  localparam int OFS_WRAP = 360;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } in_t;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [CH_W-1:0]  saturation;
    logic [CH_W-1:0]  brightness;
    logic             hue_undefined;
  } out_t;

  typedef struct packed {
    logic       grey;
    logic [1:0] sector;
    logic       neg;
  } ctl_t;

endpackage

`default_nettype wire

// ===== design/rhc_front.sv =====
// Front stages: max/min, sector and channel difference, then divider operands.
`default_nettype none

module rhc_front #(
  parameter int HUE_FRAC_BITS = rhc_pkg::HUE_FRAC_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 en,
  input  wire logic                 in_valid,
  input  wire rhc_pkg::in_t         in_data,
  output logic                      out_valid,
  output rhc_pkg::ctl_t             out_ctl,
  output logic [7:0]                out_dlt,
  output logic [7:0]                out_mx,
  output logic [7:0]                out_hrem,
  output logic [HUE_FRAC_BITS+5:0]  out_hq,
  output logic [7:0]                out_srem,
  output logic [7:0]                out_sq
);

  localparam int QW  = HUE_FRAC_BITS + 6;
  localparam int NHW = HUE_FRAC_BITS + 14;

  // stage A
  logic       a_vld_r;
  logic [7:0] a_mx_r, a_mx_nxt;
  logic [7:0] a_mn_r, a_mn_nxt;
  logic [1:0] a_sec_r, a_sec_nxt;
  logic [8:0] a_dif_r, a_dif_nxt;

  logic [8:0] d_gb, d_br, d_rg;
  logic [7:0] r, g, b;

  always_comb begin
    r = in_data.red;
    g = in_data.green;
    b = in_data.blue;
    d_gb = {1'b0, g} - {1'b0, b};
    d_br = {1'b0, b} - {1'b0, r};
    d_rg = {1'b0, r} - {1'b0, g};
    if (r >= g && r >= b) begin
      a_sec_nxt = rhc_pkg::SEC_RED;
      a_mx_nxt  = r;
      a_dif_nxt = d_gb;
    end else if (g >= b) begin
      a_sec_nxt = rhc_pkg::SEC_GRN;
      a_mx_nxt  = g;
      a_dif_nxt = d_br;
    end else begin
      a_sec_nxt = rhc_pkg::SEC_BLU;
      a_mx_nxt  = b;
      a_dif_nxt = d_rg;
    end
    a_mn_nxt = r;
    if (g < a_mn_nxt) a_mn_nxt = g;
    if (b < a_mn_nxt) a_mn_nxt = b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_mx_r  <= a_mx_nxt;
      a_mn_r  <= a_mn_nxt;
      a_sec_r <= a_sec_nxt;
      a_dif_r <= a_dif_nxt;
    end
  end

  // stage B
  logic              b_vld_r;
  rhc_pkg::ctl_t     b_ctl_r, b_ctl_nxt;
  logic [7:0]        b_dlt_r, b_dlt_nxt;
  logic [7:0]        b_mx_r;
  logic [7:0]        b_hrem_r;
  logic [QW-1:0]     b_hq_r;
  logic [7:0]        b_srem_r;
  logic [7:0]        b_sq_r;

  logic [7:0]        adif;
  logic [13:0]       m60;
  logic [NHW-1:0]    nh;
  logic [15:0]       ns;

  always_comb begin
    b_dlt_nxt = a_mx_r - a_mn_r;
    adif = a_dif_r[8] ? 8'(-a_dif_r) : a_dif_r[7:0];
    m60 = 14'(adif) * 14'd60;
    nh = NHW'(m60) << HUE_FRAC_BITS;
    ns = {b_dlt_nxt, 8'd0} - {8'd0, b_dlt_nxt};
    b_ctl_nxt.grey   = (b_dlt_nxt == 8'd0);
    b_ctl_nxt.sector = a_sec_r;
    b_ctl_nxt.neg    = a_dif_r[8];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (en) begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_ctl_r  <= b_ctl_nxt;
      b_dlt_r  <= b_dlt_nxt;
      b_mx_r   <= a_mx_r;
      b_hrem_r <= nh[NHW-1:QW];
      b_hq_r   <= nh[QW-1:0];
      b_srem_r <= ns[15:8];
      b_sq_r   <= ns[7:0];
    end
  end

  assign out_valid = b_vld_r;
  assign out_ctl   = b_ctl_r;
  assign out_dlt   = b_dlt_r;
  assign out_mx    = b_mx_r;
  assign out_hrem  = b_hrem_r;
  assign out_hq    = b_hq_r;
  assign out_srem  = b_srem_r;
  assign out_sq    = b_sq_r;

endmodule

`default_nettype wire

// ===== design/rhc_div_stage.sv =====
// One restoring-division step for the hue and saturation quotients.
`default_nettype none

module rhc_div_stage #(
  parameter int    HUE_FRAC_BITS = rhc_pkg::HUE_FRAC_BITS_DEF,
  parameter bit    DO_HUE        = 1'b1,
  parameter bit    DO_SAT        = 1'b1
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 en,
  input  wire logic                 in_valid,
  input  wire rhc_pkg::ctl_t        in_ctl,
  input  wire logic [7:0]           in_dlt,
  input  wire logic [7:0]           in_mx,
  input  wire logic [7:0]           in_hrem,
  input  wire logic [HUE_FRAC_BITS+5:0] in_hq,
  input  wire logic [7:0]           in_srem,
  input  wire logic [7:0]           in_sq,
  output logic                      out_valid,
  output rhc_pkg::ctl_t             out_ctl,
  output logic [7:0]                out_dlt,
  output logic [7:0]                out_mx,
  output logic [7:0]                out_hrem,
  output logic [HUE_FRAC_BITS+5:0]  out_hq,
  output logic [7:0]                out_srem,
  output logic [7:0]                out_sq
);

  localparam int QW = HUE_FRAC_BITS + 6;

  logic              vld_r;
  rhc_pkg::ctl_t     ctl_r;
  logic [7:0]        dlt_r, mx_r;
  logic [7:0]        hrem_r, hrem_nxt;
  logic [QW-1:0]     hq_r, hq_nxt;
  logic [7:0]        srem_r, srem_nxt;
  logic [7:0]        sq_r, sq_nxt;

  logic [8:0] ht, hd, st, sd;
  logic       hge, sge;

  always_comb begin
    ht  = {in_hrem, in_hq[QW-1]};
    hd  = ht - {1'b0, in_dlt};
    hge = (ht >= {1'b0, in_dlt});
    st  = {in_srem, in_sq[7]};
    sd  = st - {1'b0, in_mx};
    sge = (st >= {1'b0, in_mx});
    if (DO_HUE) begin
      hrem_nxt = hge ? hd[7:0] : ht[7:0];
      hq_nxt   = {in_hq[QW-2:0], hge};
    end else begin
      hrem_nxt = in_hrem;
      hq_nxt   = in_hq;
    end
    if (DO_SAT) begin
      srem_nxt = sge ? sd[7:0] : st[7:0];
      sq_nxt   = {in_sq[6:0], sge};
    end else begin
      srem_nxt = in_srem;
      sq_nxt   = in_sq;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_r  <= in_ctl;
      dlt_r  <= in_dlt;
      mx_r   <= in_mx;
      hrem_r <= hrem_nxt;
      hq_r   <= hq_nxt;
      srem_r <= srem_nxt;
      sq_r   <= sq_nxt;
    end
  end

  assign out_valid = vld_r;
  assign out_ctl   = ctl_r;
  assign out_dlt   = dlt_r;
  assign out_mx    = mx_r;
  assign out_hrem  = hrem_r;
  assign out_hq    = hq_r;
  assign out_srem  = srem_r;
  assign out_sq    = sq_r;

endmodule

`default_nettype wire

// ===== design/rhc_back.sv =====
// Output stage: sector offset, sign and wrap of the hue, grey override, output word.
`default_nettype none

module rhc_back #(
  parameter int HUE_FRAC_BITS = rhc_pkg::HUE_FRAC_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     en,
  input  wire logic                     in_valid,
  input  wire rhc_pkg::ctl_t            in_ctl,
  input  wire logic [7:0]               in_mx,
  input  wire logic [HUE_FRAC_BITS+5:0] in_hq,
  input  wire logic [7:0]               in_sq,
  output logic                          out_valid,
  output rhc_pkg::out_t                 out_data
);

  localparam int QW = HUE_FRAC_BITS + 6;
  localparam int HW = HUE_FRAC_BITS + 9;

  logic          vld_r;
  rhc_pkg::out_t dat_r, dat_nxt;

  logic [HW-1:0]    base, qx, hsum;
  logic [HW+14:0]   hext;

  always_comb begin
    case (in_ctl.sector)
      // a negative red-sector hue that truncates to zero stays zero
      rhc_pkg::SEC_RED: base = (in_ctl.neg && in_hq != '0)
                               ? HW'(rhc_pkg::OFS_WRAP) << HUE_FRAC_BITS
                               : '0;
      rhc_pkg::SEC_GRN: base = HW'(rhc_pkg::OFS_GRN) << HUE_FRAC_BITS;
      rhc_pkg::SEC_BLU: base = HW'(rhc_pkg::OFS_BLU) << HUE_FRAC_BITS;
      default:          base = '0;
    endcase
    qx   = HW'(in_hq);
    hsum = in_ctl.neg ? base - qx : base + qx;
    hext = {15'd0, hsum};
    dat_nxt.brightness = in_mx;
    if (in_ctl.grey) begin
      dat_nxt.hue           = '0;
      dat_nxt.saturation    = '0;
      dat_nxt.hue_undefined = 1'b1;
    end else begin
      dat_nxt.hue           = hext[14:0];
      dat_nxt.saturation    = in_sq;
      dat_nxt.hue_undefined = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dat_r <= dat_nxt;
    end
  end

  assign out_valid = vld_r;
  assign out_data  = dat_r;

endmodule

`default_nettype wire

// ===== design/rgb_to_hsv_converter_core.sv =====
// Top level of the RGB to HSV converter pipeline.
`default_nettype none

// Converts one 8-bit RGB pixel per clock into hue (degrees, HUE_FRAC_BITS
// fraction bits), saturation (0..255), value (largest channel) and a flag for
// black or grey pixels, whose hue and saturation read 0. Fully pipelined: a
// word is accepted every cycle while the output side takes words. Each word
// passes front stages A and B, the division stages and the output stage; the
// two restoring dividers resolve one quotient bit per stage, so the longer
// quotient sets how many division stages there are. The pipeline stalls as a
// whole when out_ready is low and a result is held; nothing is dropped or
// repeated.

module rgb_to_hsv_converter_core #(
  parameter int HUE_FRAC_BITS = rhc_pkg::HUE_FRAC_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire rhc_pkg::in_t in_data,
  output logic              out_valid,
  input  wire logic         out_ready,
  output rhc_pkg::out_t     out_data
);

  localparam int QW = HUE_FRAC_BITS + 6;
  localparam int NS = (QW > 8) ? QW : 8;

  logic en;

  logic              p_vld  [NS+1];
  rhc_pkg::ctl_t     p_ctl  [NS+1];
  logic [7:0]        p_dlt  [NS+1];
  logic [7:0]        p_mx   [NS+1];
  logic [7:0]        p_hrem [NS+1];
  logic [QW-1:0]     p_hq   [NS+1];
  logic [7:0]        p_srem [NS+1];
  logic [7:0]        p_sq   [NS+1];

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  rhc_front #(
    .HUE_FRAC_BITS(HUE_FRAC_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .in_data  (in_data),
    .out_valid(p_vld[0]),
    .out_ctl  (p_ctl[0]),
    .out_dlt  (p_dlt[0]),
    .out_mx   (p_mx[0]),
    .out_hrem (p_hrem[0]),
    .out_hq   (p_hq[0]),
    .out_srem (p_srem[0]),
    .out_sq   (p_sq[0])
  );

  for (genvar k = 0; k < NS; k++) begin : g_div
    rhc_div_stage #(
      .HUE_FRAC_BITS(HUE_FRAC_BITS),
      .DO_HUE       (k < QW),
      .DO_SAT       (k < 8)
    ) u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_valid (p_vld[k]),
      .in_ctl   (p_ctl[k]),
      .in_dlt   (p_dlt[k]),
      .in_mx    (p_mx[k]),
      .in_hrem  (p_hrem[k]),
      .in_hq    (p_hq[k]),
      .in_srem  (p_srem[k]),
      .in_sq    (p_sq[k]),
      .out_valid(p_vld[k+1]),
      .out_ctl  (p_ctl[k+1]),
      .out_dlt  (p_dlt[k+1]),
      .out_mx   (p_mx[k+1]),
      .out_hrem (p_hrem[k+1]),
      .out_hq   (p_hq[k+1]),
      .out_srem (p_srem[k+1]),
      .out_sq   (p_sq[k+1])
    );
  end

  rhc_back #(
    .HUE_FRAC_BITS(HUE_FRAC_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (p_vld[NS]),
    .in_ctl   (p_ctl[NS]),
    .in_mx    (p_mx[NS]),
    .in_hq    (p_hq[NS]),
    .in_sq    (p_sq[NS]),
    .out_valid(out_valid),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

// ===== bench/hsv_checker.sv =====
// Checker for the RGB to HSV converter: predicts each result and compares it.
module hsv_checker #(
  parameter int HUE_FRAC_BITS = rhc_pkg::HUE_FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  rhc_pkg::in_t           in_data,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  rhc_pkg::out_t          out_data,
  output int                     errors,
  output int                     outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEG_PER_SECTOR = 60;
  localparam int HUE_ONE = 1 << HUE_FRAC_BITS;
  localparam int CH_W = rhc_pkg::CH_W;
  localparam int HUE_W = rhc_pkg::HUE_W;

  rhc_pkg::out_t hsv_due[$];
  int            bad = 0;

  function automatic rhc_pkg::out_t rgb_to_hsv(rhc_pkg::in_t px);
    int r, g, b, mx, mn, dlt, dif, ofs, hue;
    logic [1:0] sec;
    rhc_pkg::out_t o;
    r  = px.red;
    g  = px.green;
    b  = px.blue;
    mx = (r >= g) ? ((r >= b) ? r : b) : ((g >= b) ? g : b);
    mn = (r <= g) ? ((r <= b) ? r : b) : ((g <= b) ? g : b);
    dlt = mx - mn;
    o.brightness = mx[CH_W-1:0];
    if (mx == 0 || dlt == 0) begin
      o.hue = '0;
      o.saturation = '0;
      o.hue_undefined = 1'b1;
      return o;
    end
    o.saturation = CH_W'((dlt * 255) / mx);
    o.hue_undefined = 1'b0;
    // red wins ties over green, green over blue
    if (r == mx) sec = rhc_pkg::SEC_RED;
    else if (g == mx) sec = rhc_pkg::SEC_GRN;
    else sec = rhc_pkg::SEC_BLU;
    case (sec)
      rhc_pkg::SEC_RED: begin
        dif = g - b;
        ofs = 0;
      end
      rhc_pkg::SEC_GRN: begin
        dif = b - r;
        ofs = rhc_pkg::OFS_GRN;
      end
      default: begin
        dif = r - g;
        ofs = rhc_pkg::OFS_BLU;
      end
    endcase
    // SV division truncates toward zero
    hue = ofs * HUE_ONE + (dif * DEG_PER_SECTOR * HUE_ONE) / dlt;
    if (hue < 0) hue += rhc_pkg::OFS_WRAP * HUE_ONE;
    o.hue = hue[HUE_W-1:0];
    return o;
  endfunction

  function automatic bit field_ok(string name, logic [15:0] want_v, logic [15:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t ns: %s expected %0d, got %0d", $time, name, want_v, got_v);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin : watch
    rhc_pkg::out_t want;
    bit            ok;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (hsv_due.size() == 0) begin
          bad++;
          $display("%0t ns: word with none expected, got hue %0d sat %0d val %0d undef %0b",
                   $time, out_data.hue, out_data.saturation, out_data.brightness,
                   out_data.hue_undefined);
        end else begin
          want = hsv_due.pop_front();
          ok = field_ok("hue", 16'(want.hue), 16'(out_data.hue));
          ok &= field_ok("saturation", 16'(want.saturation), 16'(out_data.saturation));
          ok &= field_ok("brightness", 16'(want.brightness), 16'(out_data.brightness));
          ok &= field_ok("hue_undefined", 16'(want.hue_undefined),
                         16'(out_data.hue_undefined));
          if (!ok) bad++;
        end
      end
      if (in_valid && in_ready) hsv_due.push_back(rgb_to_hsv(in_data));
    end
    errors <= bad;
    outstanding <= hsv_due.size();
  end

endmodule

// ===== bench/tb_rgb_to_hsv_converter_core.sv =====
// Testbench top for the RGB to HSV converter: stimulus, flow control and verdict.
module tb_rgb_to_hsv_converter_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PHASE_WORDS = 300;
  localparam int HOLD_CYCLES = 100;
  localparam int DRAIN_LIMIT = 20000;
  localparam int TAIL_CYCLES = 20;

  logic          clk;
  logic          rst_n;
  logic          in_valid;
  logic          in_ready;
  rhc_pkg::in_t  in_data;
  logic          out_valid;
  logic          out_ready;
  rhc_pkg::out_t out_data;
  int            errors;
  int            outstanding;

  int src_idle_pct = 36;
  int sink_idle_pct = 80;
  bit hold_go = 1'b0;

  rgb_to_hsv_converter_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  hsv_checker u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .errors      (errors),
    .outstanding (outstanding)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  initial begin
    #1_000_000;
    $display("Mismatches found");
    $finish;
  end

  // receiver: random back-pressure, one long hold-off on request
  initial begin : sink
    int  hold_left;
    bit  hold_seen;
    hold_left = 0;
    hold_seen = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_go && !hold_seen) begin
        hold_seen = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  function automatic rhc_pkg::in_t random_pixel();
    rhc_pkg::in_t px;
    int  pick, base, top_v, low_v;
    pick = $urandom_range(99);
    px.red   = 8'($urandom_range(255));
    px.green = 8'($urandom_range(255));
    px.blue  = 8'($urandom_range(255));
    if (pick < 45) begin
      return px;
    end else if (pick < 60) begin
      // near grey, tiny delta
      base = $urandom_range(2, 253);
      px.red   = 8'(base + $urandom_range(4) - 2);
      px.green = 8'(base + $urandom_range(4) - 2);
      px.blue  = 8'(base + $urandom_range(4) - 2);
    end else if (pick < 75) begin
      // ties for the largest channel
      top_v = $urandom_range(255);
      low_v = $urandom_range(top_v);
      case ($urandom_range(3))
        0: px = '{red: 8'(top_v), green: 8'(top_v), blue: 8'(low_v)};
        1: px = '{red: 8'(low_v), green: 8'(top_v), blue: 8'(top_v)};
        2: px = '{red: 8'(top_v), green: 8'(low_v), blue: 8'(top_v)};
        default: px = '{red: 8'(top_v), green: 8'(top_v), blue: 8'(top_v)};
      endcase
    end else if (pick < 88) begin
      px.red   = 8'($urandom_range(3));
      px.green = 8'($urandom_range(3));
      px.blue  = 8'($urandom_range(3));
    end else begin
      if ($urandom_range(1)) px.red   = $urandom_range(1) ? 8'hff : 8'h00;
      if ($urandom_range(1)) px.green = $urandom_range(1) ? 8'hff : 8'h00;
      if ($urandom_range(1)) px.blue  = $urandom_range(1) ? 8'hff : 8'h00;
    end
    return px;
  endfunction

  // called and returns at a falling edge
  task automatic send_pixel(input rhc_pkg::in_t px);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin : stimulus
    rhc_pkg::in_t directed[$];
    int           waited;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    directed = '{
      '{8'd0,   8'd0,   8'd0},   '{8'd255, 8'd255, 8'd255}, '{8'd128, 8'd128, 8'd128},
      '{8'd1,   8'd1,   8'd1},   '{8'd255, 8'd0,   8'd0},   '{8'd0,   8'd255, 8'd0},
      '{8'd0,   8'd0,   8'd255}, '{8'd255, 8'd255, 8'd0},   '{8'd0,   8'd255, 8'd255},
      '{8'd255, 8'd0,   8'd255}, '{8'd255, 8'd0,   8'd1},   '{8'd255, 8'd1,   8'd0},
      '{8'd1,   8'd0,   8'd0},   '{8'd0,   8'd1,   8'd0},   '{8'd0,   8'd0,   8'd1},
      '{8'd254, 8'd255, 8'd0},   '{8'd0,   8'd1,   8'd255}, '{8'd100, 8'd50,  8'd200},
      '{8'd200, 8'd201, 8'd199}, '{8'd255, 8'd128, 8'd0},   '{8'd10,  8'd0,   8'd255},
      '{8'd0,   8'd10,  8'd255}, '{8'd1,   8'd0,   8'd1},   '{8'd170, 8'd85,  8'd255}
    };
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed[i]) send_pixel(directed[i]);
    repeat (PHASE_WORDS) send_pixel(random_pixel());

    src_idle_pct  = 80;
    sink_idle_pct = 36;
    repeat (PHASE_WORDS) send_pixel(random_pixel());

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    hold_go = 1'b1;
    @(negedge clk);
    repeat (PHASE_WORDS) send_pixel(random_pixel());
    in_valid <= 1'b0;

    waited = 0;
    while (outstanding != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0 && outstanding == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
